// ===== hw/rtl/cih_pkg.sv =====
// Shared constants, codes and a helper function for the channel interval histogrammer.
// Depends on nothing; the top level uses it by scoped names.
`default_nettype none

package cih_pkg;

  // geometry
  localparam int CHANNELS_PER_SIDE = 64;
  localparam int BINS              = 1024;
  localparam int STAMP_BITS        = 48;
  localparam int COUNT_BITS        = 32;

  localparam int STRIP_BITS     = 6;
  localparam int CHAN_BITS      = 7;
  localparam int NCHAN          = 2 * CHANNELS_PER_SIDE;
  localparam int NBINS_ALL      = BINS + 2;
  localparam int BIN_BITS       = 11;
  localparam int IVAL_BITS      = STAMP_BITS + 1;
  localparam int HIST_DEPTH     = NCHAN * NBINS_ALL;
  localparam int HIST_ADDR_BITS = $clog2(HIST_DEPTH);
  localparam int LIN_HI_BITS    = $clog2(BINS);

  // configuration registers
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 7;
  localparam int STRIPS_BITS    = 7;
  localparam int SHIFT_BITS     = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIPS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHIFT  = 2'd1;

  localparam logic [STRIPS_BITS-1:0] STRIPS_RESET = 7'd32;
  localparam logic [SHIFT_BITS-1:0]  SHIFT_RESET  = 6'd13;

  // operation codes; the two upper codes both read the channel minimum
  localparam logic [1:0] OP_HIT       = 2'd0;
  localparam logic [1:0] OP_READ_HIST = 2'd1;

  // result status codes
  localparam logic [2:0] ST_FIRST = 3'd0;
  localparam logic [2:0] ST_BIN   = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  // minimum interval meaning "none yet"
  localparam logic signed [IVAL_BITS-1:0] MIN_NONE = {1'b0, {STAMP_BITS{1'b1}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // one entry of the per-channel memory
  typedef struct packed {
    logic [STAMP_BITS-1:0]        stamp;
    logic signed [IVAL_BITS-1:0]  min_ival;
  } chan_entry_t;

  // flat histogram address: channel * (BINS + 2) + bin
  function automatic logic [HIST_ADDR_BITS-1:0] hist_addr(
    input logic [CHAN_BITS-1:0] ch,
    input logic [BIN_BITS-1:0]  bin
  );
    logic [HIST_ADDR_BITS-1:0] base;
    base = HIST_ADDR_BITS'(ch) * HIST_ADDR_BITS'(NBINS_ALL);
    return base + HIST_ADDR_BITS'(bin);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cih_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module cih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/channel_interval_histogrammer_top.sv =====
// Top level of the channel interval histogrammer: control sequencer and two memories.
// Depends on cih_pkg and cih_ram.
//
// Usage:
//   Command channel: a transaction is accepted at a clock edge with start high and busy
//   low. Fields: operation_i, side_i, strip_i, timestamp_i, bin_select_i.
//   Result channel: done_o is high for exactly one cycle with status_o, interval_o,
//   bin_index_o and read_value_o; the receiver cannot stall and must take it then.
//   Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high, so a write lands at any edge with cfg_valid_i high.
// Command sequencing:
//   bad channel or first hit: the result is registered at accept, busy stays low, so the
//     next command is taken on the following cycle.
//   reads: busy through S_READ, which registers the result; no new command meanwhile.
//   binned hit: busy through S_IVAL, S_BIN and S_HIST, no new command until done:
//     channel memory read at accept, interval subtract, bin and histogram read, then the
//     histogram read-modify-write, all on the single histogram RAM port pair.
// Reset:
//   registers return to 32 strips and a shift of 13, all channels unseen; then a
//   clearing pass zeroes all 131328 histogram RAM entries, one entry a cycle, with
//   busy high. Configuration writes are taken during the pass.
`default_nettype none

module channel_interval_histogrammer_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // command channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            operation_i,
  input  wire logic                                  side_i,
  input  wire logic [cih_pkg::STRIP_BITS-1:0]        strip_i,
  input  wire logic [cih_pkg::STAMP_BITS-1:0]        timestamp_i,
  input  wire logic [cih_pkg::BIN_BITS-1:0]          bin_select_i,
  // result channel
  output logic                                       done_o,
  output logic [2:0]                                 status_o,
  output logic signed [cih_pkg::IVAL_BITS-1:0]       interval_o,
  output logic [cih_pkg::BIN_BITS-1:0]               bin_index_o,
  output logic signed [cih_pkg::IVAL_BITS-1:0]       read_value_o,
  // configuration channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [cih_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire logic [cih_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_IVAL,
    S_BIN,
    S_HIST
  } state_e;

  state_e state_q;

  // configuration registers
  logic [cih_pkg::STRIPS_BITS-1:0] strips_q;
  logic [cih_pkg::SHIFT_BITS-1:0]  shift_q;

  // per-channel seen flags
  logic [cih_pkg::NCHAN-1:0] seen_q;

  // command and working registers
  logic [1:0]                              op_q;
  logic [cih_pkg::CHAN_BITS-1:0]           ch_q;
  logic [cih_pkg::STAMP_BITS-1:0]          ts_q;
  logic                                    sel_ok_q;
  logic signed [cih_pkg::IVAL_BITS-1:0]    ival_q;
  logic signed [cih_pkg::IVAL_BITS-1:0]    min_q;
  logic [cih_pkg::BIN_BITS-1:0]            bin_q;
  logic [2:0]                              stat_q;
  logic [cih_pkg::HIST_ADDR_BITS-1:0]      hist_addr_q;
  logic [cih_pkg::HIST_ADDR_BITS-1:0]      clr_addr_q;

  // result registers
  logic                                    done_q;
  logic [2:0]                              status_q;
  logic signed [cih_pkg::IVAL_BITS-1:0]    interval_q;
  logic [cih_pkg::BIN_BITS-1:0]            bin_index_q;
  logic signed [cih_pkg::IVAL_BITS-1:0]    read_value_q;

  // memory ports
  logic                                    chan_we;
  logic [cih_pkg::CHAN_BITS-1:0]           chan_waddr;
  cih_pkg::chan_entry_t                    chan_wdata;
  cih_pkg::chan_entry_t                    chan_rdata;
  logic                                    hist_we;
  logic [cih_pkg::HIST_ADDR_BITS-1:0]      hist_waddr;
  logic [cih_pkg::COUNT_BITS-1:0]          hist_wdata;
  logic [cih_pkg::HIST_ADDR_BITS-1:0]      hist_raddr;
  logic [cih_pkg::COUNT_BITS-1:0]          hist_rdata;

  // decode of the command on the ports
  logic [cih_pkg::CHAN_BITS-1:0]           ch_in;
  logic                                    strip_ok;
  logic                                    sel_ok;
  logic [cih_pkg::BIN_BITS-1:0]            sel_safe;
  logic                                    first_hit;

  // binning of the registered interval
  logic [cih_pkg::IVAL_BITS-1:0]           ival_u;
  logic [cih_pkg::IVAL_BITS-1:0]           lin;
  logic [cih_pkg::BIN_BITS-1:0]            bin_d;
  logic [2:0]                              stat_d;
  logic signed [cih_pkg::IVAL_BITS-1:0]    min_d;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign interval_o   = interval_q;
  assign bin_index_o  = bin_index_q;
  assign read_value_o = read_value_q;

  // channel number is side * CHANNELS_PER_SIDE + strip
  assign ch_in     = {side_i, strip_i};
  assign strip_ok  = ({1'b0, strip_i} < strips_q);
  assign sel_ok    = (bin_select_i < cih_pkg::BIN_BITS'(cih_pkg::NBINS_ALL));
  assign sel_safe  = sel_ok ? bin_select_i : '0;
  assign first_hit = start && !busy && strip_ok && (operation_i == cih_pkg::OP_HIT)
                     && !seen_q[ch_in];

  // bin from interval: underflow, linear bins, overflow
  assign ival_u = ival_q;
  assign lin    = ival_u >> shift_q;
  always_comb begin
    if (ival_q[cih_pkg::IVAL_BITS-1]) begin
      bin_d  = '0;
      stat_d = cih_pkg::ST_UNDER;
    end else if (lin[cih_pkg::IVAL_BITS-1:cih_pkg::LIN_HI_BITS] != '0) begin
      bin_d  = cih_pkg::BIN_BITS'(cih_pkg::BINS + 1);
      stat_d = cih_pkg::ST_OVER;
    end else begin
      bin_d  = cih_pkg::BIN_BITS'(lin[cih_pkg::LIN_HI_BITS-1:0]) + 1'b1;
      stat_d = cih_pkg::ST_BIN;
    end
  end

  assign min_d = (ival_q < min_q) ? ival_q : min_q;

  // channel memory: first hit writes at accept, binned hit writes in the bin step
  always_comb begin
    if (state_q == S_BIN) begin
      chan_we             = 1'b1;
      chan_waddr          = ch_q;
      chan_wdata.stamp    = ts_q;
      chan_wdata.min_ival = min_d;
    end else begin
      chan_we             = first_hit;
      chan_waddr          = ch_in;
      chan_wdata.stamp    = timestamp_i;
      chan_wdata.min_ival = cih_pkg::MIN_NONE;
    end
  end

  // histogram read address: read command at accept, binned hit in the bin step
  assign hist_raddr = (state_q == S_BIN) ? cih_pkg::hist_addr(ch_q, bin_d)
                                         : cih_pkg::hist_addr(ch_in, sel_safe);

  // histogram write: clearing pass or saturating increment
  always_comb begin
    if (state_q == S_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr_q;
      hist_wdata = '0;
    end else begin
      hist_we    = (state_q == S_HIST);
      hist_waddr = hist_addr_q;
      hist_wdata = (hist_rdata == cih_pkg::COUNT_MAX) ? hist_rdata : hist_rdata + 1'b1;
    end
  end

  cih_ram #(
    .WIDTH ($bits(cih_pkg::chan_entry_t)),
    .DEPTH (cih_pkg::NCHAN)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (chan_waddr),
    .wdata_i (chan_wdata),
    .raddr_i (ch_in),
    .rdata_o (chan_rdata)
  );

  cih_ram #(
    .WIDTH (cih_pkg::COUNT_BITS),
    .DEPTH (cih_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      strips_q     <= cih_pkg::STRIPS_RESET;
      shift_q      <= cih_pkg::SHIFT_RESET;
      seen_q       <= '0;
      clr_addr_q   <= '0;
      op_q         <= '0;
      ch_q         <= '0;
      ts_q         <= '0;
      sel_ok_q     <= 1'b0;
      ival_q       <= '0;
      min_q        <= '0;
      bin_q        <= '0;
      stat_q       <= '0;
      hist_addr_q  <= '0;
      done_q       <= 1'b0;
      status_q     <= '0;
      interval_q   <= '0;
      bin_index_q  <= '0;
      read_value_q <= '0;
    end else begin
      done_q <= 1'b0;

      // configuration write transaction
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == cih_pkg::CFG_STRIPS) begin
          strips_q <= cfg_data_i;
        end else if (cfg_index_i == cih_pkg::CFG_SHIFT) begin
          shift_q <= cfg_data_i[cih_pkg::SHIFT_BITS-1:0];
        end
      end

      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == cih_pkg::HIST_ADDR_BITS'(cih_pkg::HIST_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q     <= operation_i;
            ch_q     <= ch_in;
            ts_q     <= timestamp_i;
            sel_ok_q <= sel_ok;
            if (!strip_ok) begin
              done_q       <= 1'b1;
              status_q     <= cih_pkg::ST_BAD;
              interval_q   <= '0;
              bin_index_q  <= '0;
              read_value_q <= '0;
            end else if (operation_i == cih_pkg::OP_HIT) begin
              if (!seen_q[ch_in]) begin
                seen_q[ch_in] <= 1'b1;
                done_q        <= 1'b1;
                status_q      <= cih_pkg::ST_FIRST;
                interval_q    <= '0;
                bin_index_q   <= '0;
                read_value_q  <= '0;
              end else begin
                state_q <= S_IVAL;
              end
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          done_q      <= 1'b1;
          status_q    <= cih_pkg::ST_READ;
          interval_q  <= '0;
          bin_index_q <= '0;
          if (op_q == cih_pkg::OP_READ_HIST) begin
            read_value_q <= sel_ok_q
              ? {{(cih_pkg::IVAL_BITS - cih_pkg::COUNT_BITS){1'b0}}, hist_rdata} : '0;
          end else begin
            read_value_q <= seen_q[ch_q] ? chan_rdata.min_ival : cih_pkg::MIN_NONE;
          end
          state_q <= S_IDLE;
        end
        S_IVAL: begin
          ival_q  <= {1'b0, ts_q} - {1'b0, chan_rdata.stamp};
          min_q   <= chan_rdata.min_ival;
          state_q <= S_BIN;
        end
        S_BIN: begin
          bin_q       <= bin_d;
          stat_q      <= stat_d;
          hist_addr_q <= hist_raddr;
          state_q     <= S_HIST;
        end
        S_HIST: begin
          done_q       <= 1'b1;
          status_q     <= stat_q;
          interval_q   <= ival_q;
          bin_index_q  <= bin_q;
          read_value_q <= '0;
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // bad channel answers on the next cycle
  a_bad_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !strip_ok |=> done_o && status_o == cih_pkg::ST_BAD)
    else $error("bad channel command did not answer on the next cycle");

  // a read answers after passing through S_READ
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && strip_ok && operation_i != cih_pkg::OP_HIT |-> ##2 done_o)
    else $error("read command result missing");

  // a hit on a seen channel answers after S_IVAL, S_BIN and S_HIST, with a binned status
  a_hit_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && strip_ok && operation_i == cih_pkg::OP_HIT && seen_q[ch_in]
    |-> ##4 done_o && status_o != cih_pkg::ST_FIRST)
    else $error("binned hit result missing");

  // a saturating count never wraps back to zero
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HIST |-> hist_wdata != '0)
    else $error("histogram count wrapped");

endmodule

`default_nettype wire
